@@ src/iee_pkg.sv @@
// shared types and constants of the integer expression evaluator
// no dependencies
package iee_pkg;

    localparam int unsigned MaxLenDefault = 128;
    localparam int unsigned ValW = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PCT   = 8'h25;

    localparam logic [1:0] ALU_MUL = 2'd0;
    localparam logic [1:0] ALU_DIV = 2'd1;
    localparam logic [1:0] ALU_MOD = 2'd2;

    // pending quotient-level operator
    localparam logic [1:0] QOP_NONE = 2'd0;
    localparam logic [1:0] QOP_DIV  = 2'd1;
    localparam logic [1:0] QOP_MOD  = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

endpackage

@@ src/iee_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module iee_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 128
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/iee_alu.sv @@
// iterative 64-bit multiply / signed divide / signed remainder, one bit per cycle
// depends on iee_pkg
module iee_alu import iee_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_alu_req        i_req,
    input  logic [ValW-1:0] i_a,
    input  logic [ValW-1:0] i_b,
    output logic            o_done,
    output logic [ValW-1:0] o_result
);
    localparam int unsigned CW = $clog2(ValW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_op;
    logic [ValW-1:0] r_a;
    logic [ValW-1:0] r_b;
    logic [ValW-1:0] r_acc;
    logic            r_qneg;
    logic            r_rneg;

    logic [ValW-1:0] trial;
    logic [ValW-1:0] diff;
    logic            fits;

    assign trial = {r_acc[ValW-2:0], r_b[ValW-1]};
    assign diff  = trial - r_a;
    assign fits  = trial >= r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ValW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_acc  <= '0;
            r_qneg <= i_a[ValW-1] ^ i_b[ValW-1];
            r_rneg <= i_a[ValW-1];
            if (i_req.op == ALU_MUL) begin
                r_a <= i_a;
                r_b <= i_b;
            end else begin
                r_a <= i_b[ValW-1] ? (~i_b + 1'b1) : i_b;
                r_b <= i_a[ValW-1] ? (~i_a + 1'b1) : i_a;
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[ValW-2:0], 1'b0};
                r_b <= {1'b0, r_b[ValW-1:1]};
            end else begin
                r_acc <= fits ? diff : trial;
                r_b   <= {r_b[ValW-2:0], fits};
            end
        end
    end

    always_comb begin
        case (r_op)
            ALU_MUL: o_result = r_acc;
            ALU_DIV: o_result = r_qneg ? (~r_b + 1'b1) : r_b;
            ALU_MOD: o_result = r_rneg ? (~r_acc + 1'b1) : r_acc;
            default: o_result = r_acc;
        endcase
    end

    assign o_done = r_done;
endmodule

@@ src/integer_expression_evaluator_top.sv @@
// integer expression evaluator: text store, parse sequencer, group stack
// depends on iee_pkg, iee_ram, iee_alu
//
// input channel: one beat per character (i_char_code, i_last); a beat is
//   taken when i_in_valid is high and o_in_stall is low
// up to MAX_LEN-1 characters are kept, later ones are dropped; the beat
//   with i_last high still starts evaluation
// evaluation walks the stored text once by recursive descent; open
//   parentheses push the pending sum/quotient/product state on a stack ram
// every primary value costs one multiply, every '/' or '%' one divide in the
//   shared iterative unit unless the divisor is zero or minus one; each
//   character read passes through the S_FETCH and S_LATCH states
// o_in_stall is high for the whole evaluation
// output channel: o_value is held with o_out_valid until a cycle with
//   i_out_stall low; a new expression can be collected while a result
//   waits, its own result is held back until the register is free
// reset (synchronous, i_rst_n low) empties the text store and drops any
//   pending result
module integer_expression_evaluator_top import iee_pkg::*; #(
    parameter int unsigned MAX_LEN = MaxLenDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_char_code,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [ValW-1:0] o_value
);
    localparam int unsigned LW = $clog2(MAX_LEN);
    localparam int unsigned FW = 3 * ValW + 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_LATCH = 4'd2;
    localparam logic [3:0] S_PRIM  = 4'd3;
    localparam logic [3:0] S_DIGIT = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_MULW  = 4'd6;
    localparam logic [3:0] S_AFTP  = 4'd7;
    localparam logic [3:0] S_QUOT  = 4'd8;
    localparam logic [3:0] S_QUOTW = 4'd9;
    localparam logic [3:0] S_AFTQ  = 4'd10;
    localparam logic [3:0] S_CLOSE = 4'd11;
    localparam logic [3:0] S_POP   = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [3:0]      r_state, n_state;
    logic [3:0]      r_ret, n_ret;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_pos, n_pos;
    logic [LW-1:0]   r_sp, n_sp;
    logic [7:0]      r_ch, n_ch;
    logic [ValW-1:0] r_s, n_s;
    logic            r_sop, n_sop;      // 1: subtract
    logic [ValW-1:0] r_q, n_q;
    logic [1:0]      r_qop, n_qop;
    logic [ValW-1:0] r_p, n_p;
    logic            r_neg, n_neg;
    logic [ValW-1:0] r_num, n_num;
    logic [ValW-1:0] r_v, n_v;
    logic            r_closed, n_closed;
    logic            r_ovalid, n_ovalid;
    logic [ValW-1:0] r_value, n_value;

    logic            in_acc;
    logic [7:0]      text_rdata;
    logic            stk_we;
    logic [FW-1:0]   stk_wdata;
    logic [FW-1:0]   stk_rdata;
    logic [LW-1:0]   stk_raddr;
    t_alu_req        alu_req;
    logic [ValW-1:0] alu_a, alu_b, alu_res;
    logic            alu_done;
    logic [ValW-1:0] sum_new;

    // frame fields popped from the group stack
    logic [ValW-1:0] f_s, f_q, f_p;
    logic            f_sop, f_neg;
    logic [1:0]      f_qop;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign {f_s, f_sop, f_q, f_qop, f_p, f_neg} = stk_rdata;
    assign stk_wdata  = {r_s, r_sop, r_q, r_qop, r_p, r_neg};
    assign stk_raddr  = r_sp - 1'b1;
    assign sum_new    = r_sop ? (r_s - r_q) : (r_s + r_q);

    iee_ram #(.W(8), .D(MAX_LEN)) u_text (
        .i_clk   (i_clk),
        .i_we    (in_acc && (r_len < LW'(MAX_LEN - 1))),
        .i_waddr (r_len),
        .i_wdata (i_char_code),
        .i_raddr (r_pos),
        .o_rdata (text_rdata)
    );

    iee_ram #(.W(FW), .D(MAX_LEN)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    iee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_len    = r_len;
        n_pos    = r_pos;
        n_sp     = r_sp;
        n_ch     = r_ch;
        n_s      = r_s;
        n_sop    = r_sop;
        n_q      = r_q;
        n_qop    = r_qop;
        n_p      = r_p;
        n_neg    = r_neg;
        n_num    = r_num;
        n_v      = r_v;
        n_closed = r_closed;
        n_ovalid = r_ovalid;
        n_value  = r_value;
        stk_we   = 1'b0;
        alu_req  = '{start: 1'b0, op: ALU_MUL};
        alu_a    = r_p;
        alu_b    = r_v;

        // result beat taken
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_len < LW'(MAX_LEN - 1)) begin
                        n_len = r_len + 1'b1;
                    end
                    if (i_last) begin
                        n_pos   = '0;
                        n_sp    = '0;
                        n_s     = '0;
                        n_sop   = 1'b0;
                        n_qop   = QOP_NONE;
                        n_p     = ValW'(1);
                        n_neg   = 1'b0;
                        n_ret   = S_PRIM;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LATCH;
            end
            S_LATCH: begin
                // past the end of text reads as a terminator
                n_ch    = (r_pos < r_len) ? text_rdata : 8'h00;
                n_state = r_ret;
            end
            S_PRIM: begin
                if (r_ch == CH_MINUS && !r_neg) begin
                    n_neg   = 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_PRIM;
                    n_state = S_FETCH;
                end else if (r_ch == CH_OPEN) begin
                    // save pending state of the enclosing levels
                    stk_we  = 1'b1;
                    n_sp    = r_sp + 1'b1;
                    n_s     = '0;
                    n_sop   = 1'b0;
                    n_qop   = QOP_NONE;
                    n_p     = ValW'(1);
                    n_neg   = 1'b0;
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_PRIM;
                    n_state = S_FETCH;
                end else begin
                    n_num   = '0;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (r_ch >= CH_ZERO && r_ch <= CH_NINE) begin
                    n_num   = {r_num[ValW-4:0], 3'b000} + {r_num[ValW-2:0], 1'b0}
                              + ValW'(r_ch - CH_ZERO);
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_DIGIT;
                    n_state = S_FETCH;
                end else begin
                    n_v     = r_neg ? (~r_num + 1'b1) : r_num;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                alu_req = '{start: 1'b1, op: ALU_MUL};
                n_state = S_MULW;
            end
            S_MULW: begin
                if (alu_done) begin
                    n_p     = alu_res;
                    n_state = S_AFTP;
                end
            end
            S_AFTP: begin
                if (r_ch == CH_STAR) begin
                    n_neg   = 1'b0;
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_PRIM;
                    n_state = S_FETCH;
                end else begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                alu_a = r_q;
                alu_b = r_p;
                if (r_qop == QOP_NONE) begin
                    n_q     = r_p;
                    n_state = S_AFTQ;
                end else if (r_p == '0) begin
                    // zero divisor clears the running value
                    n_q     = '0;
                    n_state = S_AFTQ;
                end else if (r_p == '1) begin
                    // divisor of minus one: wrapped negation, remainder zero
                    n_q     = (r_qop == QOP_DIV) ? (~r_q + 1'b1) : '0;
                    n_state = S_AFTQ;
                end else begin
                    alu_req = '{start: 1'b1,
                                op: (r_qop == QOP_DIV) ? ALU_DIV : ALU_MOD};
                    n_state = S_QUOTW;
                end
            end
            S_QUOTW: begin
                if (alu_done) begin
                    n_q     = alu_res;
                    n_state = S_AFTQ;
                end
            end
            S_AFTQ: begin
                if (r_ch == CH_SLASH || r_ch == CH_PCT) begin
                    n_qop   = (r_ch == CH_SLASH) ? QOP_DIV : QOP_MOD;
                    n_p     = ValW'(1);
                    n_neg   = 1'b0;
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_PRIM;
                    n_state = S_FETCH;
                end else begin
                    n_s = sum_new;
                    if (r_ch == CH_PLUS || r_ch == CH_MINUS) begin
                        n_sop   = (r_ch == CH_MINUS);
                        n_qop   = QOP_NONE;
                        n_p     = ValW'(1);
                        n_neg   = 1'b0;
                        n_pos   = r_pos + 1'b1;
                        n_ret   = S_PRIM;
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                if (r_sp == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_closed = (r_ch == CH_CLOSE);
                    n_sp     = r_sp - 1'b1;
                    n_state  = S_POP;
                end
            end
            S_POP: begin
                // group value becomes a primary of the enclosing level
                n_v   = f_neg ? (~r_s + 1'b1) : r_s;
                n_s   = f_s;
                n_sop = f_sop;
                n_q   = f_q;
                n_qop = f_qop;
                n_p   = f_p;
                n_neg = f_neg;
                if (r_closed) begin
                    n_pos   = r_pos + 1'b1;
                    n_ret   = S_MUL;
                    n_state = S_FETCH;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_value  = r_s;
                    n_len    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_len    <= '0;
            r_pos    <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_s      <= n_s;
        r_sop    <= n_sop;
        r_q      <= n_q;
        r_qop    <= n_qop;
        r_p      <= n_p;
        r_neg    <= n_neg;
        r_num    <= n_num;
        r_v      <= n_v;
        r_closed <= n_closed;
        r_value  <= n_value;
    end

    assign o_out_valid = r_ovalid;
    assign o_value     = r_value;
endmodule

@@ verif/tb_integer_expression_evaluator_top.sv @@
// testbench of the integer expression evaluator: directed table, then random expressions
// predictor is a recursive-descent evaluator over a byte queue; depends on iee_pkg and the rtl
module tb_integer_expression_evaluator_top import iee_pkg::*; ();

    localparam int MAX_LEN = 128;
    localparam int WATCHDOG_LIMIT = 60000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_char_code;
    logic                   i_last;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [ValW-1:0] o_value;

    integer_expression_evaluator_top #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_char_code(i_char_code), .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_value(o_value)
    );

    // idle percentages, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off;       // long receiver hold-off in progress

    // predictor state: characters of the current expression
    logic [7:0] expr_chars[$];
    int         cursor;

    logic [63:0] expected_values[$];
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned idle_cycles;
    bit          timed_out;

    // ---------------------------------------------------------------
    // predictor: recursive descent over expr_chars
    // ---------------------------------------------------------------
    function automatic logic [7:0] peek_char();
        if (cursor < expr_chars.size()) return expr_chars[cursor];
        return 8'h00;
    endfunction

    function automatic logic [63:0] eval_primary();
        bit          negate;
        logic [63:0] acc;
        logic [7:0]  ch;
        negate = 0;
        acc = '0;
        if (peek_char() == CH_MINUS) begin
            negate = 1;
            cursor++;
        end
        if (peek_char() == CH_OPEN) begin
            cursor++;
            acc = eval_sum();
            if (peek_char() == CH_CLOSE) cursor++;
        end else begin
            ch = peek_char();
            while (ch >= CH_ZERO && ch <= CH_NINE) begin
                acc = acc * 64'd10 + 64'(ch - CH_ZERO);
                cursor++;
                ch = peek_char();
            end
        end
        return negate ? -acc : acc;
    endfunction

    function automatic logic [63:0] eval_product();
        logic [63:0] acc;
        acc = eval_primary();
        while (peek_char() == CH_STAR) begin
            cursor++;
            acc = acc * eval_primary();
        end
        return acc;
    endfunction

    function automatic logic [63:0] eval_quotient();
        logic [63:0] acc, rhs;
        logic [7:0]  op;
        acc = eval_product();
        while (peek_char() == CH_SLASH || peek_char() == CH_PCT) begin
            op = peek_char();
            cursor++;
            rhs = eval_product();
            if (rhs == 0) acc = '0;
            // divisor of minus one: wrapped negation, remainder zero
            else if (rhs == '1) acc = (op == CH_SLASH) ? -acc : '0;
            else if (op == CH_SLASH) acc = $signed(acc) / $signed(rhs);
            else acc = $signed(acc) % $signed(rhs);
        end
        return acc;
    endfunction

    function automatic logic [63:0] eval_sum();
        logic [63:0] acc, rhs;
        logic [7:0]  op;
        acc = eval_quotient();
        while (peek_char() == CH_PLUS || peek_char() == CH_MINUS) begin
            op = peek_char();
            cursor++;
            rhs = eval_quotient();
            acc = (op == CH_PLUS) ? acc + rhs : acc - rhs;
        end
        return acc;
    endfunction

    // update predictor with one accepted beat
    function automatic void accept_char(logic [7:0] ch, logic fin);
        if (expr_chars.size() < MAX_LEN - 1) expr_chars.push_back(ch);
        if (fin) begin
            cursor = 0;
            expected_values.push_back(eval_sum());
            expr_chars.delete();
        end
    endfunction

    // ---------------------------------------------------------------
    // clock, reset, watchdog
    // ---------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall, compare accepted results
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d", o_value);
            end else begin
                if (o_value !== expected_values[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("value mismatch: expected %0d actual %0d",
                                 $signed(expected_values[0]), o_value);
                end
                void'(expected_values.pop_front());
            end
        end
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    // drive one beat; returns once accepted, valid stays up for the next beat
    task automatic send_beat(logic [7:0] ch, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        i_last      <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        accept_char(ch, fin);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == s.len() - 1);
    endtask

    // random operand text, mostly short numbers, sometimes long
    function automatic string rand_number();
        string s;
        int    n;
        s = "";
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 1) : $urandom_range(4, 1);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        if ($urandom_range(9) == 0) s = "0";
        return s;
    endfunction

    function automatic string rand_expr(int depth);
        string s;
        int    terms;
        logic [7:0] ops[6];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_STAR};
        s = "";
        terms = $urandom_range(4, 1);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) s = {s, string'(ops[$urandom_range(5)])};
            if ($urandom_range(4) == 0) s = {s, "-"};
            if (depth < 3 && $urandom_range(4) == 0) begin
                s = {s, "(", rand_expr(depth + 1)};
                if ($urandom_range(7) != 0) s = {s, ")"};
            end else if ($urandom_range(19) != 0) begin
                s = {s, rand_number()};
            end
        end
        return s;
    endfunction

    // drop valid, then wait until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
    endtask

    // directed table: text and, where obvious, the expected value
    typedef struct {
        string       text;
        bit          known;
        logic [63:0] value;
    } t_directed_row;

    t_directed_row directed_rows[] = '{
        '{"0", 1, 64'd0},
        '{"9223372036854775807", 1, 64'h7fffffffffffffff},
        '{"-9223372036854775808", 1, 64'h8000000000000000},
        '{"18446744073709551615", 1, '1},
        '{"99999999999999999999999", 0, 0},
        '{"7/0", 1, 64'd0},
        '{"7%0", 1, 64'd0},
        '{"-9223372036854775808/-1", 1, 64'h8000000000000000},
        '{"-9223372036854775808%-1", 1, 64'd0},
        '{"2+3*4", 1, 64'd14},
        '{"10-4-3", 1, 64'd3},
        '{"100/10/5", 1, 64'd2},
        '{"17%5", 1, 64'd2},
        '{"-7/2", 1, -64'sd3},
        '{"-7%2", 1, -64'sd1},
        '{"8/2*2", 1, 64'd2},
        '{"-(2+3)*2", 1, -64'sd10},
        '{"((4+1)", 1, 64'd5},
        '{"-", 1, 64'd0},
        '{"+5", 1, 64'd5},
        '{"3*", 1, 64'd0},
        '{"12a+3", 1, 64'd12},
        '{"5)+1", 1, 64'd5},
        '{"-+", 0, 0}
    };

    initial begin
        string s;
        int    items;
        i_rst_n = 0;
        i_in_valid = 0;
        i_char_code = '0;
        i_last = 0;
        i_out_stall = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        mismatch_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        timed_out = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part; typed-in values checked against the predictor's entry
        foreach (directed_rows[r]) begin
            send_text(directed_rows[r].text);
            if (directed_rows[r].known &&
                expected_values[expected_values.size()-1] !== directed_rows[r].value) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("table row %0d: expected %0d predicted %0d", r,
                             $signed(directed_rows[r].value),
                             $signed(expected_values[expected_values.size()-1]));
            end
        end
        // empty expression is a lone zero byte; an unknown byte as well
        send_beat(8'h00, 1'b1);
        send_beat(8'hff, 1'b1);
        // store full: long text, last beat dropped but still evaluates
        for (int i = 0; i < 200; i++) send_beat((i % 2) ? CH_PLUS : 8'h31, i == 199);
        drain();

        // random part in idling phases
        items = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin send_idle_pct = $urandom_range(30); recv_stall_pct = 10; end
            endcase
            if (ph == 4) begin
                // long receiver hold-off while the sender keeps going
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            while (items < (ph + 1) * 180) begin
                if ($urandom_range(9) == 0) begin
                    // noise: random bytes
                    s = "";
                    for (int k = $urandom_range(6, 1); k > 0; k--)
                        s = {s, string'(8'($urandom_range(255)))};
                end else begin
                    s = rand_expr(0);
                end
                if (s.len() == 0) s = "0";
                send_text(s);
                items += s.len();
            end
        end
        drain();
        repeat (3000) @(posedge i_clk);

        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/iee_pkg.sv
src/iee_ram.sv
src/iee_alu.sv
src/integer_expression_evaluator_top.sv
verif/tb_integer_expression_evaluator_top.sv
